### design/dets_pkg.sv
// Package for the dual event time scheduler: sizes, command and status codes,
// the stored entry type and the saturating time helpers.
// No dependencies; the scheduler and the testbench import it, dets_ram does not.
package dets_pkg;

  // List geometry and field widths.
  localparam int LIST_DEPTH = 32;
  localparam int TAG_BITS   = 4;
  localparam int SLOT_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int TIME_W     = 40;
  localparam int TV_W       = 32;
  localparam int ADDR_W     = SLOT_W + 1;
  localparam int RAM_DEPTH  = 2 * (2 ** SLOT_W);

  localparam logic signed [TIME_W-1:0] T_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic signed [TIME_W-1:0] T_MIN = {1'b1, {(TIME_W-1){1'b0}}};

  // Command codes as carried by the input channel.
  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_ADJUST   = 3'd2,
    CMD_QUERY    = 3'd3,
    CMD_DISPATCH = 3'd4,
    CMD_SUBTRACT = 3'd5
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NOTHING   = 2'd3
  } status_e;

  // One list entry as held in the memory.
  typedef struct packed {
    logic [TAG_BITS-1:0]      tag;
    logic signed [TIME_W-1:0] tm;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Negative times become zero.
  function automatic logic signed [TIME_W-1:0] clamp0(input logic signed [TIME_W-1:0] v);
    return v[TIME_W-1] ? '0 : v;
  endfunction

  // a - b, saturated to the signed time range.
  function automatic logic signed [TIME_W-1:0] sat_sub(input logic signed [TIME_W-1:0] a,
                                                       input logic signed [TIME_W-1:0] b);
    logic signed [TIME_W:0] diff;
    diff = {a[TIME_W-1], a} - {b[TIME_W-1], b};
    if (diff[TIME_W] != diff[TIME_W-1]) begin
      return diff[TIME_W] ? T_MIN : T_MAX;
    end
    return diff[TIME_W-1:0];
  endfunction

endpackage

### design/dets_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dets_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/dual_event_time_scheduler.sv
// Dual event time scheduler: two packed lists of timed events in one RAM.
// Channels: command input (in_valid_i / in_stall_o) and result output
// (out_valid_o / out_stall_i). A transfer happens at a rising edge where
// valid is high and stall is low. Every command gives exactly one result.
// Each command runs on its own through a sequencer around one memory read
// port and one write port; the next command is taken once the result has
// been handed to the output register, even while that register still waits.
// Add, an unknown command and any command with nothing to do finish without a
// list walk. Query, subtract and dispatch walk the whole list, dispatch after
// reading the remembered entry and then moving the last entry into its slot.
// Remove and adjust search for the tag, the main list first and then the
// secondary list; remove then moves the last entry into the hole.
// Each list walk reads one entry per cycle.
// Reset clears both counts and remembered slots; memory contents are left
// as they are and never read before written. When the receiver stalls, the
// result holds in the output register and the block stops after finishing
// at most one further command.
module dual_event_time_scheduler
  import dets_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                command_i,
  input  logic                      list_select_i,
  input  logic [TAG_BITS-1:0]       event_tag_i,
  input  logic signed [TV_W-1:0]    time_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [TAG_BITS-1:0]       result_tag_o,
  output logic signed [TIME_W-1:0]  result_time_o,
  output logic [SLOT_W-1:0]         result_slot_o
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SEARCH  = 8'b0000_0010,
    S_MIN     = 8'b0000_0100,
    S_FETCH   = 8'b0000_1000,
    S_SUB     = 8'b0001_0000,
    S_MOVE    = 8'b0010_0000,
    S_MOVE_WR = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

  state_e                   state_q, state_d;
  cmd_e                     cmd_q, cmd_d;
  logic                     sel_q, sel_d;
  logic [TAG_BITS-1:0]      tag_q, tag_d;
  logic signed [TIME_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]         cnt_q [2];
  logic [CNT_W-1:0]         cnt_d [2];
  logic [SLOT_W-1:0]        nx_q [2];
  logic [SLOT_W-1:0]        nx_d [2];
  logic [CNT_W-1:0]         idx_q, idx_d;
  logic                     rd_vld_q, rd_vld_d;
  logic [SLOT_W-1:0]        rd_slot_q, rd_slot_d;
  entry_t                   best_q, best_d;
  logic [SLOT_W-1:0]        best_slot_q, best_slot_d;
  logic [SLOT_W-1:0]        hit_slot_q, hit_slot_d;
  status_e                  res_status_q, res_status_d;
  logic [TAG_BITS-1:0]      res_tag_q, res_tag_d;
  logic signed [TIME_W-1:0] res_time_q, res_time_d;
  logic [SLOT_W-1:0]        res_slot_q, res_slot_d;
  logic                     out_vld_q;
  status_e                  out_status_q;
  logic [TAG_BITS-1:0]      out_tag_q;
  logic signed [TIME_W-1:0] out_time_q;
  logic [SLOT_W-1:0]        out_slot_q;
  logic                     out_load;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  entry_t                   ram_wdata, rd_entry;
  logic [ENTRY_W-1:0]       ram_rdata;

  logic [CNT_W-1:0]         cur_cnt;
  logic                     scanning, issue, hit;
  logic [CNT_W-1:0]         in_cnt;
  logic [SLOT_W-1:0]        in_nx;
  logic signed [TIME_W-1:0] tv_ext;

  assign rd_entry = entry_t'(ram_rdata);
  assign cur_cnt  = cnt_q[sel_q];
  assign in_cnt   = cnt_q[list_select_i];
  assign in_nx    = nx_q[list_select_i];
  assign tv_ext   = {{(TIME_W-TV_W){time_value_i[TV_W-1]}}, time_value_i};

  // Scan pipeline: one read issued per cycle, its data checked in the next cycle.
  assign scanning = (state_q == S_SEARCH) || (state_q == S_MIN) || (state_q == S_SUB);
  assign hit      = (state_q == S_SEARCH) && rd_vld_q && (rd_entry.tag == tag_q);
  assign issue    = scanning && (idx_q < cur_cnt) && !hit;

  assign in_stall_o = (state_q != S_IDLE);

  // Entry memory: both lists, the list select is the top address bit.
  dets_ram #(
    .Width (ENTRY_W),
    .Depth (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Command sequencer.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    sel_d        = sel_q;
    tag_d        = tag_q;
    val_d        = val_q;
    cnt_d        = cnt_q;
    nx_d         = nx_q;
    idx_d        = idx_q;
    rd_vld_d     = issue;
    rd_slot_d    = idx_q[SLOT_W-1:0];
    best_d       = best_q;
    best_slot_d  = best_slot_q;
    hit_slot_d   = hit_slot_q;
    res_status_d = res_status_q;
    res_tag_d    = res_tag_q;
    res_time_d   = res_time_q;
    res_slot_d   = res_slot_q;
    ram_we       = 1'b0;
    ram_waddr    = {sel_q, rd_slot_q};
    ram_wdata    = rd_entry;
    ram_raddr    = {sel_q, idx_q[SLOT_W-1:0]};
    out_load     = 1'b0;

    if (issue) begin
      idx_d = idx_q + 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        ram_raddr = {list_select_i, in_nx};
        if (in_valid_i) begin
          cmd_d        = cmd_e'(command_i);
          sel_d        = list_select_i;
          tag_d        = event_tag_i;
          idx_d        = '0;
          res_status_d = ST_NOTHING;
          res_tag_d    = '0;
          res_time_d   = '0;
          res_slot_d   = '0;
          state_d      = S_DONE;
          case (command_i)
            CMD_ADD: begin
              if (in_cnt == CNT_W'(LIST_DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                ram_we                = 1'b1;
                ram_waddr             = {list_select_i, in_cnt[SLOT_W-1:0]};
                ram_wdata.tag         = event_tag_i;
                ram_wdata.tm          = clamp0(tv_ext);
                cnt_d[list_select_i]  = in_cnt + 1'b1;
                res_status_d          = ST_OK;
                res_tag_d             = event_tag_i;
                res_time_d            = clamp0(tv_ext);
                res_slot_d            = in_cnt[SLOT_W-1:0];
              end
            end
            CMD_REMOVE, CMD_ADJUST: begin
              sel_d   = 1'b0;
              val_d   = clamp0(tv_ext);
              state_d = S_SEARCH;
            end
            CMD_QUERY: begin
              nx_d[list_select_i] = '0;
              if (in_cnt == '0) begin
                res_time_d = T_MAX;
              end else begin
                state_d = S_MIN;
              end
            end
            CMD_DISPATCH: begin
              if ((in_cnt != '0) && ({1'b0, in_nx} < in_cnt)) begin
                state_d = S_FETCH;
              end
            end
            CMD_SUBTRACT: begin
              if (in_cnt != '0) begin
                val_d   = tv_ext;
                state_d = S_SUB;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Tag search, main list first, then the secondary list.
      S_SEARCH: begin
        if (hit) begin
          rd_vld_d     = 1'b0;
          hit_slot_d   = rd_slot_q;
          res_status_d = ST_OK;
          res_tag_d    = tag_q;
          res_slot_d   = rd_slot_q;
          if (cmd_q == CMD_ADJUST) begin
            ram_we        = 1'b1;
            ram_wdata.tag = tag_q;
            ram_wdata.tm  = val_q;
            res_time_d    = val_q;
            state_d       = S_DONE;
          end else begin
            state_d = S_MOVE;
          end
        end else if (!issue && !rd_vld_q) begin
          if (!sel_q) begin
            sel_d = 1'b1;
            idx_d = '0;
          end else begin
            res_status_d = ST_NOT_FOUND;
            state_d      = S_DONE;
          end
        end
      end

      // Minimum search; a strict compare keeps the lowest slot on ties.
      S_MIN: begin
        if (rd_vld_q && ((rd_slot_q == '0) || (rd_entry.tm < best_q.tm))) begin
          best_d      = rd_entry;
          best_slot_d = rd_slot_q;
        end
        if (!issue && !rd_vld_q) begin
          nx_d[sel_q]  = best_slot_q;
          res_status_d = ST_OK;
          res_tag_d    = best_q.tag;
          res_time_d   = clamp0(best_q.tm);
          res_slot_d   = best_slot_q;
          state_d      = S_DONE;
        end
      end

      // Dispatch: the remembered entry has been read; its time is the elapsed.
      S_FETCH: begin
        val_d        = clamp0(rd_entry.tm);
        hit_slot_d   = nx_q[sel_q];
        res_status_d = ST_OK;
        res_tag_d    = rd_entry.tag;
        res_time_d   = clamp0(rd_entry.tm);
        res_slot_d   = nx_q[sel_q];
        idx_d        = '0;
        state_d      = S_SUB;
      end

      // Read-modify-write over the list; each slot is touched once.
      S_SUB: begin
        if (rd_vld_q) begin
          ram_we       = 1'b1;
          ram_wdata.tm = sat_sub(rd_entry.tm, val_q);
        end
        if (!issue && !rd_vld_q) begin
          if (cmd_q == CMD_DISPATCH) begin
            state_d = S_MOVE;
          end else begin
            res_status_d = ST_OK;
            state_d      = S_DONE;
          end
        end
      end

      // Read the last live entry and drop the count by one.
      S_MOVE: begin
        ram_raddr    = {sel_q, SLOT_W'(cur_cnt - 1'b1)};
        cnt_d[sel_q] = cur_cnt - 1'b1;
        state_d      = S_MOVE_WR;
      end

      // Fill the hole with the former last entry.
      S_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {sel_q, hit_slot_q};
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
      nx_q[0]   <= '0;
      nx_q[1]   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      nx_q     <= nx_d;
      rd_vld_q <= rd_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    sel_q        <= sel_d;
    tag_q        <= tag_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    rd_slot_q    <= rd_slot_d;
    best_q       <= best_d;
    best_slot_q  <= best_slot_d;
    hit_slot_q   <= hit_slot_d;
    res_status_q <= res_status_d;
    res_tag_q    <= res_tag_d;
    res_time_q   <= res_time_d;
    res_slot_q   <= res_slot_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_tag_q    <= res_tag_q;
      out_time_q   <= res_time_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign result_tag_o  = out_tag_q;
  assign result_time_o = out_time_q;
  assign result_slot_o = out_slot_q;

  // Checks on the sequencer.
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CNT_W'(LIST_DEPTH)) && (cnt_q[1] <= CNT_W'(LIST_DEPTH)))
    else $error("list count beyond list depth");

  a_rd_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_SEARCH || state_q == S_MIN || state_q == S_SUB))
    else $error("scan read data arrived outside a scan");

  a_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == S_IDLE) |-> (in_valid_i && command_i == CMD_ADD))
    else $error("memory written while idle without an add");

  a_move_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |=> (cnt_q[sel_q] + 1'b1 == $past(cnt_q[sel_q])))
    else $error("removal did not drop the list count by one");

endmodule

### test/tb_top.sv
// Self-checking testbench for dual_event_time_scheduler: a directed table and then
// phased random commands, checked against typed table results or a behavioural model.
// Depends on dets_pkg and the dual_event_time_scheduler RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dets_pkg::*;

  // Command codes that the block must treat as no-ops.
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam int WATCHDOG_LIMIT = 1500;
  localparam int DRAIN_CYCLES   = 100;
  localparam int REPORT_LIMIT   = 10;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [1:0]               status;
    logic [TAG_BITS-1:0]      tag;
    logic signed [TIME_W-1:0] due;
    logic [SLOT_W-1:0]        slot;
  } sched_result_t;

  // One row of the directed table; typed rows carry their own expected result.
  typedef struct packed {
    logic [2:0]          cmd;
    logic                sel;
    logic [TAG_BITS-1:0] tag;
    logic [TV_W-1:0]     tv;
    logic                typed;
    sched_result_t       res;
  } stim_row_t;

  typedef enum int {PH_FILL, PH_MIX, PH_SATURATE, PH_DRAIN} phase_e;
  typedef enum int {
    PICK_ADD, PICK_REMOVE, PICK_ADJUST, PICK_QUERY, PICK_PAIR,
    PICK_DISPATCH, PICK_SUBTRACT, PICK_SPARE, PICK_SATURATE, PICK_SAT_QUERY
  } pick_e;

  localparam sched_result_t NOTHING_RES   = '{ST_NOTHING, '0, '0, '0};
  localparam sched_result_t NOT_FOUND_RES = '{ST_NOT_FOUND, '0, '0, '0};
  localparam sched_result_t UNTYPED       = '0;

  localparam int N_ROWS = 24;
  localparam stim_row_t DIR_ROWS [N_ROWS] = '{
    // Empty lists straight after reset, unknown tags and the spare codes.
    '{CMD_QUERY,    1'b0, 4'd0,  32'd0,        1'b1, '{ST_NOTHING, 4'd0, T_MAX, 5'd0}},
    '{CMD_DISPATCH, 1'b0, 4'd0,  32'd0,        1'b1, NOTHING_RES},
    '{CMD_SUBTRACT, 1'b1, 4'd0,  32'd1000,     1'b1, NOTHING_RES},
    '{CMD_REMOVE,   1'b0, 4'd5,  32'd0,        1'b1, NOT_FOUND_RES},
    '{CMD_ADJUST,   1'b1, 4'd9,  32'd7,        1'b1, NOT_FOUND_RES},
    '{CMD_SPARE6,   1'b1, 4'd15, 32'hFFFFFFFF, 1'b1, NOTHING_RES},
    '{CMD_SPARE7,   1'b0, 4'd0,  32'd0,        1'b1, NOTHING_RES},
    // Adds at the extremes of the time field; negative times become zero.
    '{CMD_ADD,      1'b0, 4'd15, 32'h7FFFFFFF, 1'b1,
      '{ST_OK, 4'd15, 40'sd2147483647, 5'd0}},
    '{CMD_ADD,      1'b0, 4'd0,  32'h80000000, 1'b1, '{ST_OK, 4'd0, 40'sd0, 5'd1}},
    '{CMD_ADD,      1'b1, 4'd3,  32'd100,      1'b1, '{ST_OK, 4'd3, 40'sd100, 5'd0}},
    '{CMD_ADD,      1'b1, 4'd10, 32'hFFFFFFFF, 1'b1, '{ST_OK, 4'd10, 40'sd0, 5'd1}},
    // Query, dispatch, adjust in either list and subtraction of both extremes.
    '{CMD_QUERY,    1'b0, 4'd0,  32'd0,        1'b0, UNTYPED},
    '{CMD_DISPATCH, 1'b0, 4'd0,  32'd0,        1'b0, UNTYPED},
    '{CMD_ADJUST,   1'b0, 4'd3,  32'd500,      1'b0, UNTYPED},
    '{CMD_ADJUST,   1'b1, 4'd15, 32'd12345,    1'b0, UNTYPED},
    '{CMD_SUBTRACT, 1'b0, 4'd0,  32'h80000000, 1'b0, UNTYPED},
    '{CMD_SUBTRACT, 1'b1, 4'd0,  32'h7FFFFFFF, 1'b0, UNTYPED},
    // The remove leaves the remembered slot beyond the count, so the dispatch is stale.
    '{CMD_QUERY,    1'b1, 4'd0,  32'd0,        1'b0, UNTYPED},
    '{CMD_REMOVE,   1'b0, 4'd3,  32'd0,        1'b0, UNTYPED},
    '{CMD_DISPATCH, 1'b1, 4'd0,  32'd0,        1'b0, UNTYPED},
    '{CMD_QUERY,    1'b1, 4'd0,  32'd0,        1'b0, UNTYPED},
    '{CMD_DISPATCH, 1'b1, 4'd0,  32'd0,        1'b0, UNTYPED},
    '{CMD_REMOVE,   1'b1, 4'd15, 32'd0,        1'b0, UNTYPED},
    '{CMD_REMOVE,   1'b1, 4'd15, 32'd0,        1'b0, UNTYPED}
  };

  // Random plan: fill, mix, drive times to saturation, drain; twice over, then a mix.
  localparam phase_e PLAN [9] = '{PH_FILL, PH_MIX, PH_SATURATE, PH_DRAIN,
                                  PH_FILL, PH_MIX, PH_SATURATE, PH_DRAIN, PH_MIX};
  localparam int PLAN_LEN [9] = '{100, 150, 300, 100, 100, 150, 300, 100, 200};

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cmd_valid;
  logic                     cmd_stall;
  logic [2:0]               cmd_code;
  logic                     cmd_sel;
  logic [TAG_BITS-1:0]      cmd_tag;
  logic signed [TV_W-1:0]   cmd_ticks;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  logic [1:0]               res_status;
  logic [TAG_BITS-1:0]      res_tag;
  logic signed [TIME_W-1:0] res_time;
  logic [SLOT_W-1:0]        res_slot;

  // Model state: both event lists, their counts and remembered slots.
  logic signed [TIME_W-1:0] due_time [2][LIST_DEPTH];
  logic [TAG_BITS-1:0]      due_tag  [2][LIST_DEPTH];
  int                       live_count [2];
  int                       next_slot  [2];

  sched_result_t awaited_results [$];
  int            fail_count  = 0;
  int            idle_cycles = 0;
  int            gap_pct     = 0;
  int            stall_pct   = 0;
  int            stall_left  = 0;

  dual_event_time_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (cmd_valid),
    .in_stall_o    (cmd_stall),
    .command_i     (cmd_code),
    .list_select_i (cmd_sel),
    .event_tag_i   (cmd_tag),
    .time_value_i  (cmd_ticks),
    .out_valid_o   (res_valid),
    .out_stall_i   (res_stall),
    .status_o      (res_status),
    .result_tag_o  (res_tag),
    .result_time_o (res_time),
    .result_slot_o (res_slot)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Negative times are held at zero.
  function automatic logic signed [TIME_W-1:0] clamp_ticks(input longint v);
    return (v < 0) ? '0 : v[TIME_W-1:0];
  endfunction

  // Subtract a number of ticks from every live entry, saturating to 40 bits.
  function automatic void shift_list(input logic sel, input longint amount);
    longint diff;
    int     i;
    for (i = 0; i < live_count[sel]; i++) begin
      diff = longint'(due_time[sel][i]) - amount;
      if (diff > longint'(T_MAX)) diff = longint'(T_MAX);
      if (diff < longint'(T_MIN)) diff = longint'(T_MIN);
      due_time[sel][i] = diff[TIME_W-1:0];
    end
  endfunction

  // Apply one command to the model state and return the result it produces.
  function automatic sched_result_t scheduler_outcome(input logic [2:0] cmd,
                                                      input logic sel,
                                                      input logic [TAG_BITS-1:0] tag,
                                                      input logic [TV_W-1:0] tv);
    sched_result_t r;
    longint        ticks;
    longint        best;
    int            hit;
    int            hit_list;
    int            l;
    int            i;
    int            n;
    int            last;
    r     = NOTHING_RES;
    ticks = longint'($signed(tv));
    case (cmd)
      CMD_ADD: begin
        if (live_count[sel] >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          n = live_count[sel];
          due_time[sel][n] = clamp_ticks(ticks);
          due_tag[sel][n]  = tag;
          live_count[sel]  = n + 1;
          r = '{ST_OK, tag, due_time[sel][n], SLOT_W'(n)};
        end
      end
      CMD_REMOVE, CMD_ADJUST: begin
        // The main list is searched before the secondary one; lowest slot wins.
        r.status = ST_NOT_FOUND;
        hit      = -1;
        hit_list = 0;
        for (l = 0; l < 2 && hit < 0; l++) begin
          for (i = 0; i < live_count[l] && hit < 0; i++) begin
            if (due_tag[l][i] == tag) begin
              hit      = i;
              hit_list = l;
            end
          end
        end
        if (hit >= 0) begin
          r.status = ST_OK;
          r.tag    = tag;
          r.slot   = SLOT_W'(hit);
          if (cmd == CMD_ADJUST) begin
            due_time[hit_list][hit] = clamp_ticks(ticks);
            r.due = due_time[hit_list][hit];
          end else begin
            last = live_count[hit_list] - 1;
            due_time[hit_list][hit] = due_time[hit_list][last];
            due_tag[hit_list][hit]  = due_tag[hit_list][last];
            live_count[hit_list]    = last;
          end
        end
      end
      CMD_QUERY: begin
        next_slot[sel] = 0;
        if (live_count[sel] == 0) begin
          r.due = T_MAX;
        end else begin
          best = due_time[sel][0];
          for (i = 1; i < live_count[sel]; i++) begin
            if (due_time[sel][i] < best) begin
              best           = due_time[sel][i];
              next_slot[sel] = i;
            end
          end
          r = '{ST_OK, due_tag[sel][next_slot[sel]], clamp_ticks(best),
                SLOT_W'(next_slot[sel])};
        end
      end
      CMD_DISPATCH: begin
        // A stale remembered slot leaves the list untouched.
        if (live_count[sel] != 0 && next_slot[sel] < live_count[sel]) begin
          n     = next_slot[sel];
          last  = live_count[sel] - 1;
          r     = '{ST_OK, due_tag[sel][n], clamp_ticks(longint'(due_time[sel][n])),
                    SLOT_W'(n)};
          shift_list(sel, longint'(r.due));
          due_time[sel][n] = due_time[sel][last];
          due_tag[sel][n]  = due_tag[sel][last];
          live_count[sel]  = last;
        end
      end
      CMD_SUBTRACT: begin
        if (live_count[sel] != 0) begin
          shift_list(sel, ticks);
          r.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Mostly small times, with negative values, full-width values and extremes.
  function automatic logic [TV_W-1:0] draw_ticks();
    case ($urandom_range(9))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2, 3:    return $urandom;
      4:       return -$urandom_range(1000);
      default: return $urandom_range(5000);
    endcase
  endfunction

  // General command mix.
  function automatic pick_e mixed_pick();
    int r;
    r = $urandom_range(99);
    if (r < 22) return PICK_ADD;
    if (r < 34) return PICK_REMOVE;
    if (r < 46) return PICK_ADJUST;
    if (r < 58) return PICK_QUERY;
    if (r < 68) return PICK_PAIR;
    if (r < 76) return PICK_DISPATCH;
    if (r < 95) return PICK_SUBTRACT;
    return PICK_SPARE;
  endfunction

  // Present one command after a random gap, hold it until the transfer, then
  // record the result it must produce.
  task automatic send_command(input logic [2:0] cmd, input logic sel,
                              input logic [TAG_BITS-1:0] tag, input logic [TV_W-1:0] tv,
                              input logic typed, input sched_result_t typed_res);
    sched_result_t res;
    int            gap;
    gap = 0;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      gap = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_valid <= 1'b1;
    cmd_code  <= cmd;
    cmd_sel   <= sel;
    cmd_tag   <= tag;
    cmd_ticks <= tv;
    @(posedge clk_i);
    while (cmd_stall) @(posedge clk_i);
    res = scheduler_outcome(cmd, sel, tag, tv);
    if (typed) res = typed_res;
    awaited_results.push_back(res);
  endtask

  // One random phase of the given kind.
  task automatic run_phase(input phase_e mode, input int n_items, input logic go_up);
    pick_e               pick;
    logic                sel;
    logic                sat_sel;
    logic [TAG_BITS-1:0] tag;
    int                  sent;
    int                  r;
    sat_sel = 1'($urandom_range(1));
    sent    = 0;
    while (sent < n_items) begin
      sel = 1'($urandom_range(1));
      tag = TAG_BITS'($urandom_range(15));
      r   = $urandom_range(99);
      case (mode)
        PH_FILL:     pick = (r < 80) ? PICK_ADD : mixed_pick();
        PH_SATURATE: pick = (r < 94) ? PICK_SATURATE : (r < 98) ? PICK_SAT_QUERY : PICK_ADD;
        PH_DRAIN:    pick = (r < 40) ? PICK_REMOVE : (r < 80) ? PICK_PAIR : mixed_pick();
        default:     pick = mixed_pick();
      endcase
      case (pick)
        PICK_ADD:       send_command(CMD_ADD, sel, tag, draw_ticks(), 1'b0, UNTYPED);
        PICK_REMOVE:    send_command(CMD_REMOVE, sel, tag, $urandom, 1'b0, UNTYPED);
        PICK_ADJUST:    send_command(CMD_ADJUST, sel, tag, draw_ticks(), 1'b0, UNTYPED);
        PICK_QUERY:     send_command(CMD_QUERY, sel, tag, $urandom, 1'b0, UNTYPED);
        PICK_DISPATCH:  send_command(CMD_DISPATCH, sel, tag, $urandom, 1'b0, UNTYPED);
        PICK_SUBTRACT:  send_command(CMD_SUBTRACT, sel, tag, draw_ticks(), 1'b0, UNTYPED);
        PICK_SPARE:     send_command($urandom_range(1) ? CMD_SPARE7 : CMD_SPARE6, sel,
                                     tag, $urandom, 1'b0, UNTYPED);
        PICK_SAT_QUERY: send_command(CMD_QUERY, sat_sel, tag, $urandom, 1'b0, UNTYPED);
        PICK_SATURATE:  send_command(CMD_SUBTRACT, sat_sel, tag,
                                     go_up ? 32'h80000000 : 32'h7FFFFFFF, 1'b0, UNTYPED);
        default: begin
          // A query immediately followed by the dispatch of what it found.
          send_command(CMD_QUERY, sel, tag, $urandom, 1'b0, UNTYPED);
          send_command(CMD_DISPATCH, sel, tag, $urandom, 1'b0, UNTYPED);
          sent++;
        end
      endcase
      sent++;
    end
  endtask

  // Result checking and receiver stalls.
  always @(posedge clk_i) begin
    sched_result_t want;
    sched_result_t got;
    if (rst_ni && res_valid && !res_stall) begin
      got = '{res_status, res_tag, res_time, res_slot};
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("mismatch: result transfer with none outstanding (status %0d tag %0d)",
                   got.status, got.tag);
        end
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.tag !== want.tag ||
            got.due !== want.due || got.slot !== want.slot) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch at %0t: expected status %0d tag %0d time %0d slot %0d, ",
                     $realtime, want.status, want.tag, $signed(want.due), want.slot,
                     "got status %0d tag %0d time %0d slot %0d",
                     got.status, got.tag, $signed(got.due), got.slot);
          end
        end
      end
    end
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      res_stall  <= 1'b1;
      stall_left = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Reset, directed table, random phases and the end of the run.
  initial begin
    int p;
    int k;
    rst_ni        = 1'b0;
    cmd_valid     = 1'b0;
    cmd_code      = CMD_ADD;
    cmd_sel       = 1'b0;
    cmd_tag       = '0;
    cmd_ticks     = '0;
    live_count[0] = 0;
    live_count[1] = 0;
    next_slot[0]  = 0;
    next_slot[1]  = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct   = 25;
    stall_pct = 25;
    for (k = 0; k < N_ROWS; k++) begin
      send_command(DIR_ROWS[k].cmd, DIR_ROWS[k].sel, DIR_ROWS[k].tag, DIR_ROWS[k].tv,
                   DIR_ROWS[k].typed, DIR_ROWS[k].res);
    end

    for (p = 0; p < 9; p++) begin
      // Some phases run with no idling at all on one side or both.
      gap_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
      stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
      run_phase(PLAN[p], PLAN_LEN[p], p < 4);
    end
    cmd_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
